// ===== design/spectral_xyz_integrator_unit_defines.svh =====
// Assertion macros shared by the spectral XYZ integrator RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef SPECTRAL_XYZ_INTEGRATOR_UNIT_DEFINES_SVH
`define SPECTRAL_XYZ_INTEGRATOR_UNIT_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define SXI_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sxi assertion failed");

// consequence in the same cycle
`define SXI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sxi assertion failed");

// consequence in the following cycle
`define SXI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sxi assertion failed");

`endif

// ===== design/sxi_pkg.sv =====
// Package for the spectral XYZ integrator: sizes, codes, word and control types.
// No dependencies.
`timescale 1ns / 1ps

package sxi_pkg;

    localparam int TABLE_DEPTH     = 512;
    localparam int RADIANCE_BITS   = 24;
    localparam int WEIGHT_BITS     = 16;
    localparam int WAVELENGTH_BITS = 16;
    localparam int ACC_BITS        = 50;
    localparam int COUNT_BITS      = 10;
    localparam int COUNT_MAX       = 1023;
    localparam int TOTAL_BITS      = 64;

    localparam int ADDR_BITS  = $clog2(TABLE_DEPTH);
    localparam int TCNT_BITS  = $clog2(TABLE_DEPTH + 1);
    localparam int STEP_BITS  = WAVELENGTH_BITS + 1;
    localparam int ENTRY_BITS = WAVELENGTH_BITS + 3 * WEIGHT_BITS;

    localparam logic [1:0] LAST_CHAN = 2'd2;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_NONE   = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_TOO_FEW  = 3'd1,
        STS_BAD_STEP = 3'd2,
        STS_NONUNI   = 3'd3,
        STS_MISMATCH = 3'd4,
        STS_SAT      = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROBE,
        S_PCMP,
        S_FREAD,
        S_FCMP,
        S_MUL,
        S_ACC,
        S_DECIDE,
        S_SLO,
        S_SHI,
        S_SFIN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]                        command;
        logic [WAVELENGTH_BITS-1:0]        wavelength;
        logic signed [WEIGHT_BITS-1:0]     weight_x;
        logic signed [WEIGHT_BITS-1:0]     weight_y;
        logic signed [WEIGHT_BITS-1:0]     weight_z;
        logic signed [RADIANCE_BITS-1:0]   radiance;
        logic                              last_sample;
    } req_t;

    typedef struct packed {
        logic signed [TOTAL_BITS-1:0] x_total;
        logic signed [TOTAL_BITS-1:0] y_total;
        logic signed [TOTAL_BITS-1:0] z_total;
        logic [2:0]                   status;
    } rsp_t;

    typedef struct packed {
        logic       accept;
        logic       probe_rd;
        logic       probe_upd;
        logic       final_rd;
        logic       final_chk;
        logic       mul_sample;
        logic       acc_step;
        logic       decide;
        logic       scale_lo;
        logic       scale_hi;
        logic       scale_fin;
        logic       emit;
        logic [1:0] chan;
    } ctrl_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic hit;
        logic last;
        logic need_scale;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== design/spectral_xyz_integrator_unit.sv =====
// Top level of the spectral XYZ integrator: sequencer plus datapath.
// Depends on sxi_pkg, sxi_ctrl, sxi_dp (and through it sxi_ram).
//
//  channel | dir | handshake              | word
//  req     | in  | req_valid / req_stall  | req_t: command, wavelength, weights, radiance
//  rsp     | out | rsp_valid / rsp_stall  | rsp_t: x/y/z totals, status
//
// Append, clear and unknown commands finish on acceptance. A sample is accepted,
// then searches the n loaded entries by bisection
// (one RAM read and one compare per probe) and a final read and compare, then
// runs the three shared multiply-accumulate steps on a hit; a last sample adds
// status and emit, and scaling when the status carries totals.
// Reset clears the table count and measurement state; table contents stay.
// A result waits in the output register; only a following result stalls on it.
`timescale 1ns / 1ps

module spectral_xyz_integrator_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sxi_pkg::req_t req_word,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sxi_pkg::rsp_t rsp_word
);

    import sxi_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    sxi_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_command (req_word.command),
        .req_stall   (req_stall),
        .st          (st),
        .cmd         (cmd)
    );

    sxi_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cmd       (cmd),
        .st        (st),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

// ===== design/sxi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sxi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/sxi_ctrl.sv =====
// Sequencer for the integrator: search, multiply-accumulate and scaling steps.
// Depends on sxi_pkg.
`timescale 1ns / 1ps

module sxi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [1:0]         req_command,
    output logic               req_stall,
    input  sxi_pkg::dp_status_t st,
    output sxi_pkg::ctrl_cmd_t  cmd
);

    import sxi_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] chan_reg, chan_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.chan   = chan_reg;
        state_next = state_reg;
        chan_next  = chan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (req_command == CMD_SAMPLE)
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (st.n_zero)
                begin
                    state_next = S_FREAD;
                end
                else
                begin
                    cmd.probe_rd = 1'b1;
                    state_next   = S_PCMP;
                end
            end
            S_PCMP:
            begin
                cmd.probe_upd = 1'b1;
                state_next    = S_PROBE;
            end
            S_FREAD:
            begin
                cmd.final_rd = 1'b1;
                state_next   = S_FCMP;
            end
            S_FCMP:
            begin
                cmd.final_chk = 1'b1;
                chan_next     = '0;
                if (st.hit)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = st.last ? S_DECIDE : S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.mul_sample = 1'b1;
                state_next     = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_step = 1'b1;
                if (chan_reg == LAST_CHAN)
                begin
                    state_next = st.last ? S_DECIDE : S_IDLE;
                end
                else
                begin
                    chan_next  = chan_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                chan_next  = '0;
                state_next = st.need_scale ? S_SLO : S_EMIT;
            end
            S_SLO:
            begin
                cmd.scale_lo = 1'b1;
                state_next   = S_SHI;
            end
            S_SHI:
            begin
                cmd.scale_hi = 1'b1;
                state_next   = S_SFIN;
            end
            S_SFIN:
            begin
                cmd.scale_fin = 1'b1;
                if (chan_reg == LAST_CHAN)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    chan_next  = chan_reg + 2'd1;
                    state_next = S_SLO;
                end
            end
            S_EMIT:
            begin
                if (!st.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/sxi_dp.sv =====
// Datapath: observer table RAM, bisection registers, shared multiplier,
// accumulators, scaling and output register. Depends on sxi_pkg, sxi_ram and the assertion macro header.
`timescale 1ns / 1ps

module sxi_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  sxi_pkg::req_t      req_word,
    input  sxi_pkg::ctrl_cmd_t cmd,
    output sxi_pkg::dp_status_t st,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sxi_pkg::rsp_t      rsp_word
);

    import sxi_pkg::*;
    `include "spectral_xyz_integrator_unit_defines.svh"

    localparam int HALF_LO = ACC_BITS / 2;
    localparam int HALF_HI = ACC_BITS - HALF_LO;
    localparam int MA = ((RADIANCE_BITS > HALF_HI) ? RADIANCE_BITS : HALF_HI) + 1;
    localparam int MB = ((WEIGHT_BITS > STEP_BITS) ? WEIGHT_BITS : STEP_BITS) + 1;
    localparam int PW = MA + MB;
    localparam int PLO = HALF_LO + STEP_BITS;
    localparam int SW = ACC_BITS + 1;
    localparam int TW = ACC_BITS + STEP_BITS;

    function automatic logic [2:0] note_error(input logic [2:0] cur, input logic [2:0] code);
        logic [2:0] res;
        res = cur;
        if (code == STS_SAT)
        begin
            if (cur == STS_OK)
            begin
                res = STS_SAT;
            end
        end
        else if (cur == STS_OK || cur == STS_SAT)
        begin
            res = code;
        end
        return res;
    endfunction

    // measurement and table state
    logic [TCNT_BITS-1:0]          count_reg;
    logic signed [ACC_BITS-1:0]    acc_reg [3];
    logic [COUNT_BITS-1:0]         scnt_reg;
    logic [WAVELENGTH_BITS-1:0]    prev_reg;
    logic signed [STEP_BITS-1:0]   step_reg;
    logic [2:0]                    err_reg;
    // current sample
    logic [WAVELENGTH_BITS-1:0]    wl_reg;
    logic signed [RADIANCE_BITS-1:0] rad_reg;
    logic                          last_reg;
    // search
    logic [TCNT_BITS-1:0]          lo_reg;
    logic [TCNT_BITS-1:0]          n_reg;
    logic                          lo_lt_reg;
    // arithmetic
    logic signed [PW-1:0]          prod_reg;
    logic [PLO-1:0]                plo_reg;
    logic signed [TOTAL_BITS-1:0]  tot_reg [3];
    logic [2:0]                    stat_reg;
    logic                          sat_reg;
    // output
    logic                          out_valid_reg;
    rsp_t                          out_word_reg;

    // RAM
    logic                          ram_we, ram_re;
    logic [ADDR_BITS-1:0]          ram_waddr, ram_raddr;
    logic [ENTRY_BITS-1:0]         ram_wdata, ram_rdata;

    logic [TCNT_BITS-1:0]          half_w, probe_w;
    logic [WAVELENGTH_BITS-1:0]    rd_wl;
    logic signed [WEIGHT_BITS-1:0] rd_w [3];
    logic                          hit_w;
    logic signed [STEP_BITS-1:0]   diff_w;
    logic                          is_sample_w;
    logic [2:0]                    decide_w;
    logic                          neg_w;
    logic [ACC_BITS-1:0]           mag_w;
    logic signed [MA-1:0]          mul_a;
    logic signed [MB-1:0]          mul_b;
    logic signed [PW-1:0]          prod_w;
    logic signed [SW-1:0]          sum_w;
    logic signed [ACC_BITS-1:0]    acc_new_w;
    logic                          acc_sat_w;
    logic [TW-1:0]                 total_w, limit_w;
    logic                          scl_sat_w;
    logic signed [TOTAL_BITS-1:0]  scl_res_w;

    sxi_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign is_sample_w = cmd.accept && (req_word.command == CMD_SAMPLE);
    assign ram_we    = cmd.accept && (req_word.command == CMD_APPEND)
                       && (count_reg < TCNT_BITS'(TABLE_DEPTH));
    assign ram_waddr = count_reg[ADDR_BITS-1:0];
    assign ram_wdata = {req_word.wavelength, req_word.weight_x,
                        req_word.weight_y, req_word.weight_z};

    assign half_w    = n_reg >> 1;
    assign probe_w   = lo_reg + half_w;
    assign ram_re    = cmd.probe_rd || cmd.final_rd;
    assign ram_raddr = cmd.final_rd ? lo_reg[ADDR_BITS-1:0] : probe_w[ADDR_BITS-1:0];

    assign rd_wl    = ram_rdata[ENTRY_BITS-1 -: WAVELENGTH_BITS];
    assign rd_w[0]  = ram_rdata[3*WEIGHT_BITS-1 -: WEIGHT_BITS];
    assign rd_w[1]  = ram_rdata[2*WEIGHT_BITS-1 -: WEIGHT_BITS];
    assign rd_w[2]  = ram_rdata[WEIGHT_BITS-1:0];
    assign hit_w    = lo_lt_reg && (rd_wl == wl_reg);

    assign diff_w = $signed({1'b0, req_word.wavelength}) - $signed({1'b0, prev_reg});

    always_comb
    begin
        priority if (scnt_reg < COUNT_BITS'(2))
        begin
            decide_w = STS_TOO_FEW;
        end
        else if (step_reg[STEP_BITS-1] || step_reg == '0)
        begin
            decide_w = STS_BAD_STEP;
        end
        else
        begin
            decide_w = err_reg;
        end
    end

    // shared multiplier: radiance by weight, or magnitude half by step
    assign neg_w = acc_reg[cmd.chan][ACC_BITS-1];
    assign mag_w = neg_w ? (~acc_reg[cmd.chan] + 1'b1) : acc_reg[cmd.chan];

    always_comb
    begin
        if (cmd.mul_sample)
        begin
            mul_a = MA'(rad_reg);
            mul_b = MB'(rd_w[cmd.chan]);
        end
        else
        begin
            mul_a = cmd.scale_hi ? $signed(MA'(mag_w[ACC_BITS-1:HALF_LO]))
                                 : $signed(MA'(mag_w[HALF_LO-1:0]));
            mul_b = $signed(MB'(step_reg[STEP_BITS-1:0]));
        end
    end

    assign prod_w = mul_a * mul_b;

    assign sum_w     = SW'(acc_reg[cmd.chan]) + SW'(prod_reg);
    assign acc_sat_w = sum_w[SW-1] != sum_w[SW-2];
    assign acc_new_w = acc_sat_w ? (sum_w[SW-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                                : {1'b0, {(ACC_BITS-1){1'b1}}})
                                 : sum_w[ACC_BITS-1:0];

    assign total_w   = (TW'(prod_reg[PW-2:0]) << HALF_LO) + TW'(plo_reg);
    assign limit_w   = neg_w ? TW'({1'b1, {(TOTAL_BITS-1){1'b0}}})
                             : TW'({1'b0, {(TOTAL_BITS-1){1'b1}}});
    assign scl_sat_w = total_w > limit_w;
    assign scl_res_w = scl_sat_w ? (neg_w ? {1'b1, {(TOTAL_BITS-1){1'b0}}}
                                          : {1'b0, {(TOTAL_BITS-1){1'b1}}})
                                 : (neg_w ? -$signed(total_w[TOTAL_BITS-1:0])
                                          : $signed(total_w[TOTAL_BITS-1:0]));

    // table fill and bisection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lo_reg    <= '0;
            n_reg     <= '0;
            lo_lt_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.accept && req_word.command == CMD_CLEAR)
            begin
                count_reg <= '0;
            end
            if (is_sample_w)
            begin
                lo_reg <= '0;
                n_reg  <= count_reg;
            end
            else if (cmd.probe_upd)
            begin
                if (rd_wl < wl_reg)
                begin
                    lo_reg <= probe_w + 1'b1;
                    n_reg  <= n_reg - half_w - 1'b1;
                end
                else
                begin
                    n_reg <= half_w;
                end
            end
            if (cmd.final_rd)
            begin
                lo_lt_reg <= lo_reg < count_reg;
            end
        end
    end

    // measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
            scnt_reg   <= '0;
            prev_reg   <= '0;
            step_reg   <= '0;
            err_reg    <= STS_OK;
            last_reg   <= 1'b0;
        end
        else if (cmd.emit)
        begin
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
            scnt_reg   <= '0;
            prev_reg   <= '0;
            step_reg   <= '0;
            err_reg    <= STS_OK;
        end
        else if (is_sample_w)
        begin
            if (scnt_reg == COUNT_BITS'(1))
            begin
                step_reg <= diff_w;
            end
            else if (scnt_reg >= COUNT_BITS'(2) && diff_w != step_reg)
            begin
                err_reg <= note_error(err_reg, STS_NONUNI);
            end
            prev_reg <= req_word.wavelength;
            if (scnt_reg < COUNT_BITS'(COUNT_MAX))
            begin
                scnt_reg <= scnt_reg + 1'b1;
            end
            last_reg <= req_word.last_sample;
        end
        else if (cmd.final_chk && !hit_w)
        begin
            err_reg <= note_error(err_reg, STS_MISMATCH);
        end
        else if (cmd.acc_step)
        begin
            acc_reg[cmd.chan] <= acc_new_w;
            if (acc_sat_w)
            begin
                err_reg <= note_error(err_reg, STS_SAT);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (is_sample_w)
        begin
            wl_reg  <= req_word.wavelength;
            rad_reg <= req_word.radiance;
        end
        if (cmd.mul_sample || cmd.scale_lo || cmd.scale_hi)
        begin
            prod_reg <= prod_w;
        end
        if (cmd.scale_hi)
        begin
            plo_reg <= prod_reg[PLO-1:0];
        end
        if (cmd.decide)
        begin
            stat_reg   <= decide_w;
            sat_reg    <= 1'b0;
            tot_reg[0] <= '0;
            tot_reg[1] <= '0;
            tot_reg[2] <= '0;
        end
        else if (cmd.scale_fin)
        begin
            tot_reg[cmd.chan] <= scl_res_w;
            if (scl_sat_w)
            begin
                sat_reg <= 1'b1;
            end
        end
        if (cmd.emit)
        begin
            out_word_reg.x_total <= tot_reg[0];
            out_word_reg.y_total <= tot_reg[1];
            out_word_reg.z_total <= tot_reg[2];
            out_word_reg.status  <= sat_reg ? STS_SAT : stat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    assign st.n_zero     = (n_reg == '0);
    assign st.hit        = hit_w;
    assign st.last       = last_reg;
    assign st.need_scale = (decide_w == STS_OK) || (decide_w == STS_SAT);
    assign st.out_busy   = out_valid_reg && rsp_stall;

    // a clear may leave lo_reg above the count; it only matters once a search runs
    `SXI_ASSERT_IMP(a_lo_bounded, cmd.final_rd, lo_reg <= count_reg)
    `SXI_ASSERT_IMP(a_probe_in_table, cmd.probe_rd, probe_w < count_reg)
    `SXI_ASSERT_NXT(a_emit_clears, cmd.emit, out_valid_reg && scnt_reg == '0)

endmodule
